@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define BOLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define BOLE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/bole_pkg.sv @@
`timescale 1ns / 1ps

package bole_pkg;

  // Default sizes of the list.
  localparam int DEPTH_DEFAULT     = 64;
  localparam int ITEM_BITS_DEFAULT = 32;

  // Field widths of the request and response items.
  localparam int OP_W  = 3;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int LEN_W = 7;
  localparam int ST_W  = 2;

  // Request codes.
  localparam logic [OP_W-1:0] OP_PUSH        = 3'd0;
  localparam logic [OP_W-1:0] OP_POP         = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT      = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE_ONE   = 3'd3;
  localparam logic [OP_W-1:0] OP_ERASE_RANGE = 3'd4;
  localparam logic [OP_W-1:0] OP_READ        = 3'd5;
  localparam logic [OP_W-1:0] OP_WRITE       = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR       = 3'd7;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  // Result handed from the sequencer to the output stage.
  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [LEN_W-1:0] length_after;
    logic [ST_W-1:0]  status;
  } result_t;

endpackage

@@ hw/rtl/bole_req_if.sv @@
`timescale 1ns / 1ps

interface bole_req_if import bole_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  req_type;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] end_position;
  logic [VAL_W-1:0] item_value;

  modport source (output valid, req_type, position, end_position, item_value, input ready);
  modport sink (input valid, req_type, position, end_position, item_value, output ready);
endinterface

@@ hw/rtl/bole_rsp_if.sv @@
`timescale 1ns / 1ps

interface bole_rsp_if import bole_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] read_value;
  logic [LEN_W-1:0] length_after;
  logic [ST_W-1:0]  status;

  modport source (output valid, read_value, length_after, status, input ready);
  modport sink (input valid, read_value, length_after, status, output ready);
endinterface

@@ hw/rtl/bounded_ordered_list_engine_top.sv @@
`timescale 1ns / 1ps
// Push, write, clear, errors and inserts or erases that move nothing go straight to the
// finish state; pop and read pass through a RAM read wait, erases that move items through
// the shift state, and inserts that move items through the shift and put states.
// Items are moved one per cycle through the list RAM.
// A new request is taken in the cycle after the previous response enters the output slot.
// Synchronous active-high reset empties the list; stored items are not cleared.

module bounded_ordered_list_engine_top import bole_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int ITEM_BITS = ITEM_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  bole_req_if.sink   req,
  bole_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [ITEM_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [ITEM_BITS-1:0] mem_rdata;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;

  bole_seq #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  bole_ram #(
    .WIDTH (ITEM_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bole_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rsp       (rsp)
  );

endmodule

@@ hw/rtl/bole_ram.sv @@
`timescale 1ns / 1ps

module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/bole_seq.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bole_seq import bole_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int ITEM_BITS = ITEM_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  bole_req_if.sink                 req,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [ITEM_BITS-1:0]     mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [ITEM_BITS-1:0]     mem_rdata,
  output logic                     res_valid,
  input  logic                     res_ready,
  output result_t                  res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W + 1) ? CW : POS_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDWAIT = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]           state;
  logic [CW-1:0]        count;
  logic [AW-1:0]        pos_r;
  logic [ITEM_BITS-1:0] val_r;
  logic [AW-1:0]        src;
  logic [AW-1:0]        dst;
  logic [AW-1:0]        pend_dst;
  logic [CW-1:0]        rem;
  logic                 pend;
  logic                 shift_up;
  logic                 put;
  logic [VAL_W-1:0]     rd_value;
  logic [ST_W-1:0]      status;

  logic [XW-1:0]        pos_x;
  logic [XW-1:0]        last_x;
  logic [XW-1:0]        cnt_x;
  logic [XW-1:0]        depth_x;
  logic [ITEM_BITS-1:0] item;

  // Widened views of the request fields for the range checks.
  always_comb begin
    pos_x   = XW'(req.position);
    cnt_x   = XW'(count);
    depth_x = XW'(DEPTH);
    item    = ITEM_BITS'(req.item_value);
    if (req.req_type == OP_ERASE_ONE) begin
      last_x = XW'(req.position);
    end else begin
      last_x = XW'(req.end_position);
    end
  end

  assign req.ready = (state == S_IDLE);

  // Memory port: direct accesses on accept, moves during a shift, the new item's write in S_PUT.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_dst;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = src;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (req.req_type)
            OP_PUSH: begin
              if (cnt_x < depth_x) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count);
                mem_wdata = item;
              end
            end
            OP_POP: begin
              if (count != '0) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(cnt_x - XW'(1));
              end
            end
            OP_READ: begin
              if (pos_x < cnt_x) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(req.position);
              end
            end
            OP_WRITE: begin
              if (pos_x < cnt_x) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(req.position);
                mem_wdata = item;
              end
            end
            OP_INSERT: begin
              // Insert at the tail needs no shift.
              if (pos_x == cnt_x && cnt_x < depth_x) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(req.position);
                mem_wdata = item;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        mem_we = pend;
        mem_re = (rem != '0);
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = val_r;
      end
      default: begin
      end
    endcase
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            rd_value <= '0;
            status   <= ST_OK;
            state    <= S_FINISH;
            pos_r    <= AW'(req.position);
            val_r    <= item;
            pend     <= 1'b0;
            case (req.req_type)
              OP_PUSH: begin
                if (cnt_x >= depth_x) begin
                  status <= ST_FULL;
                end else begin
                  count <= CW'(cnt_x + XW'(1));
                end
              end
              OP_POP: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  count <= CW'(cnt_x - XW'(1));
                  state <= S_RDWAIT;
                end
              end
              OP_INSERT: begin
                if (pos_x > cnt_x) begin
                  status <= ST_RANGE;
                end else if (cnt_x >= depth_x) begin
                  status <= ST_FULL;
                end else begin
                  count <= CW'(cnt_x + XW'(1));
                  if (pos_x != cnt_x) begin
                    // Move the tail up one place, highest entry first.
                    state    <= S_SHIFT;
                    src      <= AW'(cnt_x - XW'(1));
                    dst      <= AW'(count);
                    rem      <= CW'(cnt_x - pos_x);
                    shift_up <= 1'b1;
                    put      <= 1'b1;
                  end
                end
              end
              OP_ERASE_ONE, OP_ERASE_RANGE: begin
                if (pos_x >= cnt_x || last_x >= cnt_x) begin
                  status <= ST_RANGE;
                end else if (pos_x <= last_x) begin
                  count <= CW'(cnt_x - (last_x - pos_x + XW'(1)));
                  if (last_x + XW'(1) != cnt_x) begin
                    // Move the tail down over the gap, lowest entry first.
                    state    <= S_SHIFT;
                    src      <= AW'(last_x + XW'(1));
                    dst      <= AW'(req.position);
                    rem      <= CW'(cnt_x - last_x - XW'(1));
                    shift_up <= 1'b0;
                    put      <= 1'b0;
                  end
                end
              end
              OP_READ: begin
                if (pos_x >= cnt_x) begin
                  status <= ST_RANGE;
                end else begin
                  state <= S_RDWAIT;
                end
              end
              OP_WRITE: begin
                if (pos_x >= cnt_x) begin
                  status <= ST_RANGE;
                end
              end
              default: begin
                count <= '0;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          rd_value <= VAL_W'(mem_rdata);
          state    <= S_FINISH;
        end
        S_SHIFT: begin
          // Each read lands in the next cycle as a write to its destination.
          pend <= (rem != '0);
          if (rem != '0) begin
            pend_dst <= dst;
            rem      <= rem - CW'(1);
            if (shift_up) begin
              src <= src - AW'(1);
              dst <= dst - AW'(1);
            end else begin
              src <= src + AW'(1);
              dst <= dst + AW'(1);
            end
          end else if (put) begin
            state <= S_PUT;
          end else begin
            state <= S_FINISH;
          end
        end
        S_PUT: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid        = (state == S_FINISH);
  assign res.read_value   = rd_value;
  assign res.length_after = LEN_W'(count);
  assign res.status       = status;

  `BOLE_ASSERT(count_bound, XW'(count) <= XW'(DEPTH), "item count above list depth")
  `BOLE_ASSERT_IMP(no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "read and write of one entry")
  `BOLE_ASSERT_IMP(pend_in_shift, pend, state == S_SHIFT, "pending move outside a shift")

endmodule

@@ hw/rtl/bole_out.sv @@
`timescale 1ns / 1ps

module bole_out import bole_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     res_valid,
  output logic     res_ready,
  input  result_t  res,
  bole_rsp_if.source rsp
);

  logic    out_valid;
  result_t out_data;

  // The slot takes a new result when empty or when its item leaves this cycle.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_value   = out_data.read_value;
  assign rsp.length_after = out_data.length_after;
  assign rsp.status       = out_data.status;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bole_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEFAULT;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int PHASE_ITEMS  = 170;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIX    = 2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] last;
    logic [VAL_W-1:0] val;
  } list_req_t;

  typedef struct {
    list_req_t req;
    bit        typed;
    result_t   want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bole_req_if req ();
  bole_rsp_if rsp ();

  bounded_ordered_list_engine_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Shadow copy of the list contents and its length.
  logic [VAL_W-1:0] list_mem [LIST_DEPTH];
  int unsigned      list_len;

  result_t     pending_results [$];
  script_row_t script_q [$];

  // Travels with the request payload: a hand-written expectation, if any.
  bit      pend_typed;
  result_t pend_want;

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned sent_items;
  int unsigned errors;
  int unsigned cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the shadow list and returns the response it causes.
  function automatic result_t list_apply(list_req_t it);
    result_t     r;
    int unsigned gap;
    int          i;
    r.read_value = '0;
    r.status     = ST_OK;
    case (it.op)
      OP_PUSH: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = it.val;
          list_len++;
        end
      end
      OP_POP: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          list_len--;
          r.read_value = list_mem[list_len];
        end
      end
      OP_INSERT: begin
        // A position past the end is reported before a full list.
        if (it.pos > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > it.pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[it.pos] = it.val;
          list_len++;
        end
      end
      OP_ERASE_ONE: begin
        if (it.pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          list_len--;
          for (i = it.pos; i < list_len; i++) list_mem[i] = list_mem[i+1];
        end
      end
      OP_ERASE_RANGE: begin
        // Both ends must lie inside the list; a reversed range is a no-op.
        if (it.pos >= list_len || it.last >= list_len) begin
          r.status = ST_RANGE;
        end else if (it.pos <= it.last) begin
          gap = it.last - it.pos + 1;
          list_len -= gap;
          for (i = it.pos; i < list_len; i++) list_mem[i] = list_mem[i+gap];
        end
      end
      OP_READ: begin
        if (it.pos >= list_len) r.status = ST_RANGE;
        else r.read_value = list_mem[it.pos];
      end
      OP_WRITE: begin
        if (it.pos >= list_len) r.status = ST_RANGE;
        else list_mem[it.pos] = it.val;
      end
      default: begin
        // Clear drops the length only; stored values stay in place.
        list_len = 0;
      end
    endcase
    r.length_after = LEN_W'(list_len);
    return r;
  endfunction

  // Picks a request code with weights that push the list length one way or the other.
  function automatic logic [OP_W-1:0] pick_op(int mode);
    int          w [8];
    int unsigned roll;
    int          acc;
    int          k;
    case (mode)
      MODE_GROW:   w = '{30, 5, 25, 5, 3, 15, 16, 1};
      MODE_SHRINK: w = '{10, 25, 8, 22, 12, 10, 12, 1};
      default:     w = '{18, 14, 16, 12, 8, 14, 16, 2};
    endcase
    roll = $urandom_range(99);
    acc  = 0;
    for (k = 0; k < 8; k++) begin
      acc += w[k];
      if (roll < acc) return OP_W'(k);
    end
    return OP_CLEAR;
  endfunction

  // Mostly legal positions for the current length, some on the boundary, some anywhere.
  function automatic list_req_t pick_request(int mode);
    list_req_t   it;
    int unsigned len;
    int unsigned roll;
    int unsigned hi;
    int unsigned span;
    len     = list_len;
    it.op   = pick_op(mode);
    it.val  = $urandom;
    it.last = POS_W'($urandom_range(63));
    roll    = $urandom_range(99);
    if (roll < 75 && len > 0) begin
      hi = (it.op == OP_INSERT) ? len : len - 1;
      if (hi > 63) hi = 63;
      it.pos = POS_W'($urandom_range(hi));
    end else if (roll < 90) begin
      it.pos = POS_W'((len > 63) ? 63 : len);
    end else begin
      it.pos = POS_W'($urandom_range(63));
    end
    if (it.op == OP_ERASE_RANGE && it.pos < len) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        span = len - 1 - it.pos;
        if (span > 3) span = 3;
        it.last = POS_W'(it.pos + $urandom_range(span));
      end else if (roll < 90) begin
        it.last = POS_W'($urandom_range(len - 1));
      end
    end
    return it;
  endfunction

  task automatic add_row(logic [OP_W-1:0] op, int pos, int last, logic [VAL_W-1:0] val,
                         bit typed, logic [VAL_W-1:0] rd, int len, logic [ST_W-1:0] st);
    script_row_t row;
    row.req.op            = op;
    row.req.pos           = POS_W'(pos);
    row.req.last          = POS_W'(last);
    row.req.val           = val;
    row.typed             = typed;
    row.want.read_value   = rd;
    row.want.length_after = LEN_W'(len);
    row.want.status       = st;
    script_q.insert(script_q.size(), row);
  endtask

  // Moves to the next falling edge, idling the request side at random.
  task automatic next_slot();
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Drives one request item at the current falling edge and waits for it to be taken.
  task automatic send_item(list_req_t it, bit typed, result_t want);
    req.valid        <= 1'b1;
    req.req_type     <= it.op;
    req.position     <= it.pos;
    req.end_position <= it.last;
    req.item_value   <= it.val;
    pend_typed       <= typed;
    pend_want        <= want;
    sent_items++;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Grows the list to its capacity, then tries to add past it.
  task automatic fill_list();
    list_req_t it;
    result_t   none;
    none = '0;
    it   = '0;
    forever begin
      next_slot();
      if (list_len >= LIST_DEPTH) break;
      it     = pick_request(MODE_GROW);
      it.op  = ($urandom_range(1) == 0) ? OP_PUSH : OP_INSERT;
      it.pos = POS_W'($urandom_range(list_len));
      send_item(it, 1'b0, none);
    end
    it.op = OP_PUSH;
    send_item(it, 1'b0, none);
    next_slot();
    it.op  = OP_INSERT;
    it.pos = POS_W'($urandom_range(63));
    send_item(it, 1'b0, none);
  endtask

  // Receiver stalls at random.
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Predicts on every accepted request item and checks every accepted response item.
  always @(posedge clk) begin
    list_req_t it;
    result_t   got;
    result_t   want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        it.op   = req.req_type;
        it.pos  = req.position;
        it.last = req.end_position;
        it.val  = req.item_value;
        got     = list_apply(it);
        pending_results.insert(pending_results.size(), pend_typed ? pend_want : got);
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: response with none expected: read_value %h length_after %0d status %0d",
                   $time, rsp.read_value, rsp.length_after, rsp.status);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %h, got %h",
                     $time, want.read_value, rsp.read_value);
            errors++;
          end
          if (rsp.length_after !== want.length_after) begin
            $display("%0t: length_after mismatch, expected %0d, got %0d",
                     $time, want.length_after, rsp.length_after);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, rsp.status);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    list_req_t   it;
    result_t     none;
    script_row_t row;
    int          mode;
    int          mode_left;
    int          phase;
    none             = '0;
    list_len         = 0;
    errors           = 0;
    cycles           = 0;
    sent_items       = 0;
    mode             = MODE_GROW;
    mode_left        = 0;
    req.valid        = 1'b0;
    req.req_type     = OP_PUSH;
    req.position     = '0;
    req.end_position = '0;
    req.item_value   = '0;
    rsp.ready        = 1'b0;
    pend_typed       = 1'b0;
    pend_want        = '0;
    snd_idle_pct     = 11;
    rcv_idle_pct     = 73;

    // Errors on an empty list, then growth, no-op and bounds cases, then clear, a pop and a push.
    add_row(OP_POP,         0,  0,  32'h0000_0000, 1, 32'h0, 0, ST_EMPTY);
    add_row(OP_READ,        0,  0,  32'h0000_0000, 1, 32'h0, 0, ST_RANGE);
    add_row(OP_ERASE_ONE,   0,  0,  32'h0000_0000, 1, 32'h0, 0, ST_RANGE);
    add_row(OP_ERASE_RANGE, 0,  0,  32'h0000_0000, 1, 32'h0, 0, ST_RANGE);
    add_row(OP_WRITE,       0,  0,  32'h0000_0001, 1, 32'h0, 0, ST_RANGE);
    add_row(OP_INSERT,      1,  0,  32'h0000_0002, 1, 32'h0, 0, ST_RANGE);
    add_row(OP_INSERT,      0,  0,  32'hFFFF_FFFF, 1, 32'h0, 1, ST_OK);
    add_row(OP_PUSH,        0,  0,  32'h0000_0000, 1, 32'h0, 2, ST_OK);
    add_row(OP_PUSH,        63, 63, 32'hA5A5_A5A5, 1, 32'h0, 3, ST_OK);
    add_row(OP_READ,        0,  0,  32'h0000_0000, 1, 32'hFFFF_FFFF, 3, ST_OK);
    add_row(OP_INSERT,      1,  0,  32'h1234_5678, 0, 32'h0, 0, ST_OK);
    add_row(OP_READ,        1,  0,  32'h0000_0000, 0, 32'h0, 0, ST_OK);
    add_row(OP_WRITE,       0,  0,  32'h5A5A_5A5A, 0, 32'h0, 0, ST_OK);
    add_row(OP_ERASE_RANGE, 2,  1,  32'h0000_0000, 1, 32'h0, 4, ST_OK);
    add_row(OP_ERASE_RANGE, 0,  63, 32'h0000_0000, 1, 32'h0, 4, ST_RANGE);
    add_row(OP_READ,        63, 0,  32'h0000_0000, 1, 32'h0, 4, ST_RANGE);
    add_row(OP_INSERT,      63, 63, 32'hFFFF_FFFF, 1, 32'h0, 4, ST_RANGE);
    add_row(OP_INSERT,      4,  0,  32'h0F0F_0F0F, 0, 32'h0, 0, ST_OK);
    add_row(OP_ERASE_RANGE, 1,  2,  32'h0000_0000, 0, 32'h0, 0, ST_OK);
    add_row(OP_ERASE_ONE,   0,  0,  32'h0000_0000, 0, 32'h0, 0, ST_OK);
    add_row(OP_READ,        1,  0,  32'h0000_0000, 0, 32'h0, 0, ST_OK);
    add_row(OP_POP,         0,  0,  32'h0000_0000, 0, 32'h0, 0, ST_OK);
    add_row(OP_CLEAR,       0,  0,  32'h0000_0000, 1, 32'h0, 0, ST_OK);
    add_row(OP_POP,         0,  0,  32'h0000_0000, 1, 32'h0, 0, ST_EMPTY);
    add_row(OP_PUSH,        0,  0,  32'h0000_0007, 1, 32'h0, 1, ST_OK);

    // Reset is held, then released at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script_q[n]) begin
      row = script_q[n];
      next_slot();
      send_item(row.req, row.typed, row.want);
    end

    // Random traffic under three idling patterns, each after a full drain.
    for (phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          snd_idle_pct = 11;
          rcv_idle_pct = 73;
        end
        1: begin
          snd_idle_pct = 73;
          rcv_idle_pct = 11;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      fill_list();
      while (sent_items < script_q.size() + (phase + 1) * PHASE_ITEMS) begin
        if (mode_left == 0) begin
          mode      = $urandom_range(MODE_MIX);
          mode_left = $urandom_range(60, 20);
        end
        mode_left--;
        next_slot();
        it = pick_request(mode);
        send_item(it, 1'b0, none);
      end
    end

    // Let any stray response show up before the verdict.
    wait_drained();
    repeat (LIST_DEPTH + 8) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
